// ===== design/assert_macros.svh =====
// Assertion macros used by the checker of the core reservation scheduler.
// No dependencies; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/crs_pkg.sv =====
// Shared types and constants of the core reservation scheduler.
// No dependencies; used by crs_cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  localparam int CORE_W   = 7;
  localparam int THREAD_W = 8;
  localparam int FIRST_W  = 6;
  localparam int KIND_W   = 3;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int MAX_CORES_DEF  = 64;

  localparam logic [CORE_W-1:0] TOTAL_CORES_RESET = CORE_W'(24);

  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED   = 3'd0,
    KIND_QUEUED    = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_EXCEEDS   = 3'd3,
    KIND_WAITER    = 3'd4,
    KIND_RELEASED  = 3'd5,
    KIND_UNDERFLOW = 3'd6
  } kind_t;

  // One wait-list entry
  typedef struct packed {
    logic [CORE_W-1:0]   cores;
    logic [THREAD_W-1:0] thread;
  } wait_entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/crs_cell.sv =====
// One wait-list cell: holds a waiter entry, loads it or takes its upper neighbor's.
// Depends on crs_pkg for the entry and control types.
`timescale 1ns / 1ps
`default_nettype none

module crs_cell (
  input  wire                      clk,
  input  crs_pkg::cell_ctrl_t      ctrl,
  input  crs_pkg::wait_entry_t     load_data,
  input  crs_pkg::wait_entry_t     neighbor,
  output crs_pkg::wait_entry_t     q
);

  // Load wins over shift; otherwise hold
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= neighbor;
    end
  end

endmodule

`default_nettype wire

// ===== design/core_reservation_scheduler.sv =====
// Top level of the core reservation scheduler: sequencer, counters and a row of wait-list cells.
// Depends on crs_pkg and crs_cell.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  in      | in_valid/in_ready  | func, core_count, thread_id
//  out     | out_valid/out_ready| result_kind, grant_thread, grant_first_core,
//          |                    | grant_count, free_cores
//  cfg     | cfg_we             | cfg_data (total_cores)
//
// A reserve is decided in ST_EXEC; ST_FINISH writes its result to the output register.
// A release passes ST_EXEC, ST_SCAN if waiters are listed, then ST_FINISH. In ST_SCAN the wait
// list rotates one entry per cycle through the head cell, which is compared to the
// free cores, so every waiter listed at acceptance is visited once and arrival order is kept.
// One transaction is in work at a time; a finished result waits in the output
// register while the next transaction is accepted, and stalls only the result write.
// Reset (rst, synchronous) empties the list and clears the active count.
`timescale 1ns / 1ps
`default_nettype none

module core_reservation_scheduler #(
  parameter int WAIT_DEPTH = crs_pkg::WAIT_DEPTH_DEF,
  parameter int MAX_CORES  = crs_pkg::MAX_CORES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              func,
  input  wire  [crs_pkg::CORE_W-1:0]       core_count,
  input  wire  [crs_pkg::THREAD_W-1:0]     thread_id,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [crs_pkg::KIND_W-1:0]       result_kind,
  output logic [crs_pkg::THREAD_W-1:0]     grant_thread,
  output logic [crs_pkg::FIRST_W-1:0]      grant_first_core,
  output logic [crs_pkg::CORE_W-1:0]       grant_count,
  output logic [crs_pkg::CORE_W-1:0]       free_cores,
  input  wire                              cfg_we,
  input  wire  [crs_pkg::CORE_W-1:0]       cfg_data
);

  localparam int CNT_W    = $clog2(WAIT_DEPTH + 1);
  localparam int CoreMax  = (1 << crs_pkg::CORE_W) - 1;
  localparam int PoolCap  = (MAX_CORES < CoreMax) ? MAX_CORES : CoreMax;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                       state;
  logic [crs_pkg::CORE_W-1:0]   total_cores;
  logic [crs_pkg::CORE_W-1:0]   active_count;
  logic [CNT_W-1:0]             waiter_count;
  logic [CNT_W-1:0]             scan_left;
  logic                         found;

  logic                         op_func;
  logic [crs_pkg::CORE_W-1:0]   op_count;
  logic [crs_pkg::THREAD_W-1:0] op_thread;

  crs_pkg::kind_t               res_kind;
  logic [crs_pkg::THREAD_W-1:0] res_thread;
  logic [crs_pkg::FIRST_W-1:0]  res_first;
  logic [crs_pkg::CORE_W-1:0]   res_count;

  logic [crs_pkg::CORE_W-1:0]   pool;
  logic [crs_pkg::CORE_W-1:0]   avail;
  logic                         rsv_fit;
  logic                         rsv_exceeds;
  logic                         list_full;
  logic                         rsv_queue;
  logic                         scan_fit;
  logic                         out_free;

  crs_pkg::wait_entry_t         cell_q [WAIT_DEPTH];
  crs_pkg::wait_entry_t         cell_load;
  crs_pkg::wait_entry_t         head;

  // Pool size clamped to the build limit, and free cores now
  assign pool  = (total_cores > crs_pkg::CORE_W'(PoolCap)) ?
                 crs_pkg::CORE_W'(PoolCap) : total_cores;
  assign avail = (active_count >= pool) ? '0 : pool - active_count;

  // Reserve decision on the held transaction
  assign rsv_fit     = (op_count <= avail);
  assign rsv_exceeds = (op_count > pool);
  assign list_full   = (waiter_count == CNT_W'(WAIT_DEPTH));
  assign rsv_queue   = (state == ST_EXEC) && (op_func == crs_pkg::FUNC_RESERVE) &&
                       !rsv_fit && !rsv_exceeds && !list_full;

  // Head of the rotating list
  assign head     = cell_q[0];
  assign scan_fit = (state == ST_SCAN) && !found && (head.cores <= avail);

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Enqueue writes the new entry; a scan pushes a kept head back at the tail
  assign cell_load = (state == ST_SCAN) ? head :
                     crs_pkg::wait_entry_t'{cores: op_count, thread: op_thread};

  // Row of wait-list cells, each fed by its upper neighbor, the last one by itself
  for (genvar j = 0; j < WAIT_DEPTH; j++) begin : g_cell
    crs_pkg::cell_ctrl_t  ctrl;
    crs_pkg::wait_entry_t nbr;

    assign ctrl.shift = (state == ST_SCAN);
    assign ctrl.load  = (rsv_queue && (CNT_W'(j) == waiter_count)) ||
                        ((state == ST_SCAN) && !scan_fit &&
                         (CNT_W'(j + 1) == waiter_count));

    if (j == WAIT_DEPTH - 1) begin : g_last
      assign nbr = cell_q[j];
    end else begin : g_mid
      assign nbr = cell_q[j + 1];
    end

    crs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (cell_load),
      .neighbor  (nbr),
      .q         (cell_q[j])
    );
  end

  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      total_cores  <= crs_pkg::TOTAL_CORES_RESET;
      active_count <= '0;
      waiter_count <= '0;
      scan_left    <= '0;
      found        <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_cores <= cfg_data;
      end

      // Raise the result into a free output register, drop it once taken
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_func   <= func;
            op_count  <= core_count;
            op_thread <= thread_id;
            state     <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          found <= 1'b0;
          if (op_func == crs_pkg::FUNC_RESERVE) begin
            state <= ST_FINISH;
            if (rsv_fit) begin
              res_kind     <= crs_pkg::KIND_GRANTED;
              res_thread   <= op_thread;
              res_first    <= (op_count != '0) ? active_count[crs_pkg::FIRST_W-1:0] : '0;
              res_count    <= op_count;
              active_count <= active_count + op_count;
            end else begin
              res_thread <= '0;
              res_first  <= '0;
              res_count  <= '0;
              if (rsv_exceeds) begin
                res_kind <= crs_pkg::KIND_EXCEEDS;
              end else if (list_full) begin
                res_kind <= crs_pkg::KIND_FULL;
              end else begin
                res_kind     <= crs_pkg::KIND_QUEUED;
                waiter_count <= waiter_count + 1'b1;
              end
            end
          end else begin
            res_thread <= '0;
            res_first  <= '0;
            res_count  <= '0;
            if (op_count > active_count) begin
              active_count <= '0;
              res_kind     <= crs_pkg::KIND_UNDERFLOW;
            end else begin
              active_count <= active_count - op_count;
              res_kind     <= crs_pkg::KIND_RELEASED;
            end
            scan_left <= waiter_count;
            state     <= (waiter_count == '0) ? ST_FINISH : ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Pop the head once; grant the first fit, rotate everything else
          if (scan_fit) begin
            found        <= 1'b1;
            res_thread   <= head.thread;
            res_count    <= head.cores;
            res_first    <= (head.cores != '0) ? active_count[crs_pkg::FIRST_W-1:0] : '0;
            active_count <= active_count + head.cores;
            waiter_count <= waiter_count - 1'b1;
            if (res_kind == crs_pkg::KIND_RELEASED) begin
              res_kind <= crs_pkg::KIND_WAITER;
            end
          end
          scan_left <= scan_left - 1'b1;
          if (scan_left == CNT_W'(1)) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            result_kind      <= res_kind;
            grant_thread     <= res_thread;
            grant_first_core <= res_first;
            grant_count      <= res_count;
            free_cores       <= avail;
            state            <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/crs_checker.sv =====
// Port-level checker for the core reservation scheduler, bound to the top level.
// Depends on crs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crs_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [crs_pkg::KIND_W-1:0]    result_kind,
  input wire [crs_pkg::THREAD_W-1:0]  grant_thread,
  input wire [crs_pkg::FIRST_W-1:0]   grant_first_core,
  input wire [crs_pkg::CORE_W-1:0]    grant_count
);

  logic no_grant_kind;

  // Kinds that never carry a grant
  assign no_grant_kind = (result_kind == crs_pkg::KIND_QUEUED) ||
                         (result_kind == crs_pkg::KIND_FULL) ||
                         (result_kind == crs_pkg::KIND_EXCEEDS) ||
                         (result_kind == crs_pkg::KIND_RELEASED);

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // One transaction in work at a time
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // Rejections, queueing and plain releases report an empty grant
  `ASSERT_IMPLY(a_no_grant, clk, rst, out_valid && no_grant_kind,
                grant_count == '0 && grant_thread == '0 && grant_first_core == '0)

  // A zero-core grant starts at core zero
  `ASSERT_IMPLY(a_zero_first, clk, rst, out_valid && grant_count == '0,
                grant_first_core == '0)

endmodule

bind core_reservation_scheduler crs_checker u_crs_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .result_kind      (result_kind),
  .grant_thread     (grant_thread),
  .grant_first_core (grant_first_core),
  .grant_count      (grant_count)
);

`default_nettype wire
